// File: hdl/orpr_pkg.sv
// orpr_pkg: shared types, codes and float compare for the rule remap block
// no dependencies
package orpr_pkg;

  localparam int unsigned RuleTestW = 2;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 5;
  localparam int unsigned IdxW      = 4;

  localparam logic [RuleTestW-1:0] TEST_EQ = 2'd0;
  localparam logic [RuleTestW-1:0] TEST_NE = 2'd1;
  localparam logic [RuleTestW-1:0] TEST_GT = 2'd2;
  localparam logic [RuleTestW-1:0] TEST_LT = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_REMAP = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [IdxW-1:0]      rule_slot;
    logic [RuleTestW-1:0] rule_test;
    logic [WordW-1:0]     rule_threshold;
    logic [WordW-1:0]     rule_replacement;
    logic [WordW-1:0]     pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] pixel_out;
    logic             changed;
    logic [IdxW-1:0]  matched_rule;
  } out_item_t;

  // rule entry held by one cell
  typedef struct packed {
    logic [RuleTestW-1:0] test;
    logic [WordW-1:0]     threshold;
    logic [WordW-1:0]     replacement;
  } rule_t;

  function automatic logic is_nan(input logic [WordW-1:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
  endfunction

  // C float semantics, nan compares false except not-equal
  function automatic logic rule_holds(input logic [RuleTestW-1:0] t,
                                      input logic [WordW-1:0] p,
                                      input logic [WordW-1:0] h);
    logic nan, both_zero, eq, lt, mag_lt;
    nan       = is_nan(p) || is_nan(h);
    both_zero = (p[30:0] == 31'd0) && (h[30:0] == 31'd0);
    eq        = !nan && (both_zero || (p == h));
    mag_lt    = p[30:0] < h[30:0];
    if (nan || both_zero)   lt = 1'b0;
    else if (p[31] != h[31]) lt = p[31];
    else if (p[31])          lt = (h[30:0] < p[30:0]);
    else                     lt = mag_lt;
    unique case (t)
      TEST_EQ: return eq;
      TEST_NE: return !eq;
      TEST_GT: return !nan && !eq && !lt;
      TEST_LT: return lt;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// File: hdl/orpr_cell.sv
// orpr_cell: one rule entry and one pipeline stage of the rule chain
// depends on orpr_pkg
module orpr_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_en,
  input  orpr_pkg::rule_t     load_rule,
  input  logic                active,
  input  logic                vld_i,
  input  orpr_pkg::out_item_t res_i,
  input  logic [31:0]         pix_i,
  output logic                vld_o,
  output orpr_pkg::out_item_t res_o,
  output logic [31:0]         pix_o,
  input  logic                adv
);
  orpr_pkg::rule_t     rule_r;
  logic                vld_r;
  orpr_pkg::out_item_t res_r, res_nxt;
  logic [31:0]         pix_r;

  always_comb begin
    res_nxt = res_i;
    if (active && !res_i.changed &&
        orpr_pkg::rule_holds(rule_r.test, pix_i, rule_r.threshold)) begin
      res_nxt.pixel_out    = rule_r.replacement;
      res_nxt.changed      = 1'b1;
      res_nxt.matched_rule = orpr_pkg::IdxW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) rule_r <= load_rule;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
    if (adv) begin
      res_r <= res_nxt;
      pix_r <= pix_i;
    end
  end

  assign vld_o = vld_r;
  assign res_o = res_r;
  assign pix_o = pix_r;
endmodule

// File: hdl/ordered_rule_pixel_remap.sv
// ordered_rule_pixel_remap: top level, a chain of rule cells with an output register
// depends on orpr_pkg and orpr_cell
//
// A pixel request can enter the chain every cycle and walks one rule cell per cycle
// while the chain is not stalled, so pixel throughput is one request per clock; each
// pixel passes through every rule cell and then the output register. Load requests
// write a cell's rule directly and produce no result; a load waits until no pixel is
// left in the cells, so that pixels already taken still see the rules in force when
// they were accepted. rule_count of 0 behaves as 1; values above RULES saturate. The
// chain stalls as a whole when the output register is full and not taken.
module ordered_rule_pixel_remap #(
  parameter int unsigned RULES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  orpr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output orpr_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  logic [4:0] rule_count_r;
  logic [8:0] eff_count;
  logic       adv;
  logic       busy;
  logic       out_valid_r;
  orpr_pkg::out_item_t out_r;
  orpr_pkg::rule_t     load_rule;

  logic                vld_c [RULES+1];
  orpr_pkg::out_item_t res_c [RULES+1];
  logic [31:0]         pix_c [RULES+1];

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) rule_count_r <= 5'd1;
    else if (cfg_valid) rule_count_r <= cfg_data;
  end

  assign eff_count = (rule_count_r == 5'd0) ? 9'd1 : {4'd0, rule_count_r};
  assign adv       = !out_valid_r || out_ready;

  // any pixel still inside the cells
  always_comb begin
    busy = 1'b0;
    for (int k = 1; k <= RULES; k++) busy = busy | vld_c[k];
  end

  assign in_ready = adv && ((in_data.op == orpr_pkg::OP_REMAP) || !busy);

  assign load_rule.test        = in_data.rule_test;
  assign load_rule.threshold   = in_data.rule_threshold;
  assign load_rule.replacement = in_data.rule_replacement;

  assign vld_c[0] = in_valid && in_ready && (in_data.op == orpr_pkg::OP_REMAP);
  assign pix_c[0] = in_data.pixel_in;
  assign res_c[0] = '{pixel_out: in_data.pixel_in, changed: 1'b0, matched_rule: '0};

  for (genvar g = 0; g < RULES; g++) begin : g_cell
    logic ld;
    assign ld = in_valid && in_ready && (in_data.op == orpr_pkg::OP_LOAD) &&
                ({4'd0, in_data.rule_slot} == 8'(g));
    orpr_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .load_en(ld), .load_rule(load_rule),
      .active(9'(g) < eff_count), .vld_i(vld_c[g]), .res_i(res_c[g]),
      .pix_i(pix_c[g]), .vld_o(vld_c[g+1]), .res_o(res_c[g+1]),
      .pix_o(pix_c[g+1]), .adv(adv)
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_c[RULES];
    end
    if (adv) out_r <= res_c[RULES];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");
  a_no_in_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while chain stalled");
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.changed |-> out_data.matched_rule == '0)
    else $error("match index without match");
endmodule
